// File: hdl/mbps_pkg.sv
// shared types and constants of the masked byte pattern scanner
package mbps_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [2:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [2:0] REG_BYTE_MASK      = 3'd2;
  localparam logic [2:0] REG_PATTERN_LENGTH = 3'd3;
  localparam logic [2:0] REG_ALIGNMENT_LOG2 = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int OUT_W      = 32;

  // reset values of the configuration registers
  localparam logic [15:0] BYTE_MASK_RST      = 16'hFFFF;
  localparam logic [4:0]  PATTERN_LENGTH_RST = 5'd16;

  typedef struct packed {
    logic [63:0] pattern_low;
    logic [63:0] pattern_high;
    logic [15:0] byte_mask;
    logic [4:0]  pattern_length;
    logic [1:0]  alignment_log2;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [OUT_W-1:0] offset;
  } hit_t;

endpackage

// File: hdl/masked_byte_pattern_scanner_unit.sv
// top level of the masked byte pattern scanner
//
//  channel   direction  payload                               handshake
//  in_*      slave      tdata: data_byte, tuser: first flag   tvalid/tready
//  out_*     master     tdata: match_offset                   tvalid/tready
//  cfg_*     write      index selects register, wdata value   cfg_we only
//
// one byte is taken per cycle while the output buffer has room; a match offset
// is registered in turn: the window register takes the byte at the transfer edge,
// then the compare lands in the output register, or in the skid entry if that is held
// reset (rst_n low, synchronous) empties the window, the counter and the buffer
// and loads the register defaults
// a two-entry output buffer lets input transfers go on while a result waits; input
// stalls when held results and the item being compared fill both and none is popped
module masked_byte_pattern_scanner_unit import mbps_pkg::*; #(
  parameter int PATTERN_BYTES = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic                  in_tuser,   // [0] first_of_region
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // [31:0] match_offset
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t                          cfg_r;
  logic                          accept;
  logic [PATTERN_BYTES-1:0][7:0] win;
  logic [OFFSET_BITS:0]          seen;
  logic                          item_valid;
  hit_t                          hit;

  // configuration registers, bits above each register's width dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_low    <= '0;
      cfg_r.pattern_high   <= '0;
      cfg_r.byte_mask      <= BYTE_MASK_RST;
      cfg_r.pattern_length <= PATTERN_LENGTH_RST;
      cfg_r.alignment_log2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    cfg_r.pattern_low    <= cfg_wdata;
        REG_PATTERN_HIGH:   cfg_r.pattern_high   <= cfg_wdata;
        REG_BYTE_MASK:      cfg_r.byte_mask      <= cfg_wdata[15:0];
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[4:0];
        REG_ALIGNMENT_LOG2: cfg_r.alignment_log2 <= cfg_wdata[1:0];
        default: ;  // unknown index ignored
      endcase
    end
  end

  assign accept = in_tvalid && in_tready;

  // stage one: shift the byte in and count it
  mbps_window #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_window (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .data_byte       (in_tdata),
    .first_of_region (in_tuser),
    .win             (win),
    .seen            (seen),
    .item_valid      (item_valid)
  );

  // stage two: all byte compares in parallel, offset and alignment checks
  mbps_matcher #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .OFFSET_BITS   (OFFSET_BITS)
  ) u_matcher (
    .cfg        (cfg_r),
    .win        (win),
    .seen       (seen),
    .item_valid (item_valid),
    .hit        (hit)
  );

  // result register with skid entry
  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .hit       (hit),
    .item_busy (item_valid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_ready (out_tready)
  );

endmodule

// File: hdl/mbps_window.sv
// byte window shift register and saturating offset counter
module mbps_window import mbps_pkg::*; #(
  parameter int PATTERN_BYTES = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [7:0]                      data_byte,
  input  logic                            first_of_region,
  output logic [PATTERN_BYTES-1:0][7:0]   win,
  output logic [OFFSET_BITS:0]            seen,
  output logic                            item_valid
);

  logic [PATTERN_BYTES-1:0][7:0] win_r, win_nxt;
  logic [OFFSET_BITS:0]          seen_r, seen_nxt;
  logic                          item_valid_r;

  always_comb begin
    win_nxt  = win_r;
    seen_nxt = seen_r;
    if (accept) begin
      // newest byte at position zero, restart clears the older bytes
      for (int k = 1; k < PATTERN_BYTES; k++) begin
        win_nxt[k] = first_of_region ? 8'd0 : win_r[k-1];
      end
      win_nxt[0] = data_byte;
      if (first_of_region) begin
        seen_nxt = (OFFSET_BITS+1)'(1);
      end else if (seen_r != '1) begin
        seen_nxt = seen_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r        <= '0;
      seen_r       <= '0;
      item_valid_r <= 1'b0;
    end else begin
      win_r        <= win_nxt;
      seen_r       <= seen_nxt;
      item_valid_r <= accept;
    end
  end

  assign win        = win_r;
  assign seen       = seen_r;
  assign item_valid = item_valid_r;

endmodule

// File: hdl/mbps_matcher.sv
// masked compare of the window against the pattern, start offset and alignment check
module mbps_matcher import mbps_pkg::*; #(
  parameter int PATTERN_BYTES = 16,
  parameter int OFFSET_BITS   = 32
) (
  input  cfg_t                            cfg,
  input  logic [PATTERN_BYTES-1:0][7:0]   win,
  input  logic [OFFSET_BITS:0]            seen,
  input  logic                            item_valid,
  output hit_t                            hit
);

  localparam int         SEEN_W = OFFSET_BITS + 1;
  localparam logic [6:0] PB7    = 7'(PATTERN_BYTES);

  logic [6:0]        len_wide;
  logic [SEEN_W-1:0] start;
  logic              all_ok;
  logic              enough;
  logic              start_ok;
  logic              aligned;
  logic [2:0]        align_mask;

  always_comb begin
    logic [6:0]   j_idx;
    logic [127:0] pat_all;
    logic [7:0]   pat_byte;
    logic         must;

    pat_all = {cfg.pattern_high, cfg.pattern_low};

    len_wide = {2'b00, cfg.pattern_length};
    if (len_wide == 7'd0) begin
      len_wide = 7'd1;
    end else if (len_wide > PB7) begin
      len_wide = PB7;
    end

    // window byte k lines up with pattern byte len-1-k
    all_ok = 1'b1;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      j_idx    = len_wide - 7'd1 - 7'(k);
      pat_byte = pat_all[{j_idx[3:0], 3'b000} +: 8];
      must     = (j_idx < 7'd16) && cfg.byte_mask[j_idx[3:0]];
      if ((7'(k) < len_wide) && must && (win[k] != pat_byte)) begin
        all_ok = 1'b0;
      end
    end

    unique case (cfg.alignment_log2)
      2'd0:    align_mask = 3'b000;
      2'd1:    align_mask = 3'b001;
      2'd2:    align_mask = 3'b011;
      default: align_mask = 3'b111;
    endcase

    start    = seen - SEEN_W'(len_wide);
    enough   = seen >= SEEN_W'(len_wide);
    start_ok = !start[OFFSET_BITS];
    aligned  = (start[2:0] & align_mask) == 3'b000;
  end

  assign hit.valid = item_valid && enough && start_ok && aligned && all_ok;

  generate
    if (SEEN_W >= OUT_W) begin : g_trunc
      assign hit.offset = start[OUT_W-1:0];
    end else begin : g_ext
      assign hit.offset = {{(OUT_W-SEEN_W){1'b0}}, start};
    end
  endgenerate

endmodule

// File: hdl/mbps_out_buf.sv
// two-entry result buffer: output register plus skid register
module mbps_out_buf import mbps_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  hit_t             hit,
  input  logic             item_busy,
  output logic             in_ready,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data,
  input  logic             out_ready
);

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  logic [OUT_W-1:0] skid_data_r, skid_data_nxt;
  logic             pop;
  logic [1:0]       used;

  assign pop  = out_valid_r && out_ready;
  // results held plus the item still in the compare stage
  assign used = {1'b0, out_valid_r} + {1'b0, skid_valid_r} + {1'b0, item_busy};
  assign in_ready = (used < 2'd2) || ((used == 2'd2) && pop);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
    if (hit.valid) begin
      if (!out_valid_r || (pop && !skid_valid_r)) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = hit.offset;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = hit.offset;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
